// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// clocked property, off while rst is high
`define IMF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("imf assertion failed");
// clocked property, checked in reset too
`define IMF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("imf assertion failed");
`else
`define IMF_ASSERT(label, clk, rst, prop)
`define IMF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hw/rtl/imf_pkg.sv =====
// Shared constants for the Ising Metropolis flip block
package imf_pkg;

   localparam int SIDE_DEFAULT = 64;

   // request field widths
   localparam int SITE_W = 6;
   localparam int DRAW_W = 32;
   localparam int REQ_W  = 48;

   // response field widths
   localparam int DE_W    = 5;
   localparam int E_OUT_W = 15;
   localparam int M_OUT_W = 14;
   localparam int CNT_W   = 32;
   localparam int RSP_W   = 72;

   // register port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // register index, taken from the word-address bit of paddr
   localparam logic REG_THR_FOUR  = 1'b0;
   localparam logic REG_THR_EIGHT = 1'b1;

endpackage

// ===== hw/rtl/imf_lattice.sv =====
// Spin lattice storage: two row-wide copies, registered reads
module imf_lattice #(
   parameter int LATTICE_SIDE = imf_pkg::SIDE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [$clog2(LATTICE_SIDE)-1:0] rd_up_addr,
   input  logic [$clog2(LATTICE_SIDE)-1:0] rd_dn_addr,
   input  logic [$clog2(LATTICE_SIDE)-1:0] rd_ctr_addr,
   input  logic                            wr_en,
   input  logic [$clog2(LATTICE_SIDE)-1:0] wr_addr,
   input  logic [LATTICE_SIDE-1:0]         wr_data,
   output logic [LATTICE_SIDE-1:0]         up_row,
   output logic [LATTICE_SIDE-1:0]         dn_row,
   output logic [LATTICE_SIDE-1:0]         ctr_row
);

   // one bit per spin, 1 = spin -1; one row per entry
   // neighbor copy serves the rows above and below, center copy the own row
   logic [LATTICE_SIDE-1:0] nb_mem  [LATTICE_SIDE];
   logic [LATTICE_SIDE-1:0] ctr_mem [LATTICE_SIDE];

   logic [LATTICE_SIDE-1:0] up_row_ff;
   logic [LATTICE_SIDE-1:0] dn_row_ff;
   logic [LATTICE_SIDE-1:0] ctr_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         nb_mem[wr_addr]  <= wr_data;
         ctr_mem[wr_addr] <= wr_data;
      end
   end

   // read returns the old row on a same-edge write; caller forwards
   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_row_ff  <= nb_mem[rd_up_addr];
         dn_row_ff  <= nb_mem[rd_dn_addr];
         ctr_row_ff <= ctr_mem[rd_ctr_addr];
      end
   end

   assign up_row  = up_row_ff;
   assign dn_row  = dn_row_ff;
   assign ctr_row = ctr_row_ff;

endmodule

// ===== hw/rtl/ising_metropolis_flip.sv =====
// Top level: one Metropolis spin-flip trial per request on a periodic square lattice.
// Request path: the rows are read into the lattice registers at the accepting edge, and the
//   trial is evaluated and registered in the response register once that slot is free.
// Throughput: one request per cycle while responses are taken, set by the single read-modify-write
//   of the center row; a write to a row read in the same cycle is forwarded, so hazards never stall.
// Reset: synchronous; then a clearing pass over every row sets every spin to +1,
//   during which no request is accepted (register writes are taken throughout).
`include "assert_macros.svh"

module ising_metropolis_flip #(
   parameter int LATTICE_SIDE = imf_pkg::SIDE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // request: [5:0] site_row, [11:6] site_col, [43:12] accept_draw, [47:44] zero
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [imf_pkg::REQ_W-1:0]  req_tdata,
   // response: [0] flipped, [5:1] energy_change, [20:6] total_energy,
   // [34:21] total_magnetization, [66:35] accepted_count, [71:67] zero
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [imf_pkg::RSP_W-1:0]  rsp_tdata,
   // register port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [imf_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [imf_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [imf_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import imf_pkg::*;

   localparam int ROW_W     = $clog2(LATTICE_SIDE);
   localparam int SITES     = LATTICE_SIDE * LATTICE_SIDE;
   localparam int ENERGY_W  = $clog2(2 * SITES + 1) + 1;
   localparam int MAG_W     = $clog2(SITES + 1) + 1;
   localparam int SITE_SPAN = 2 ** SITE_W;

   localparam logic [ROW_W-1:0]           LAST_ROW   = ROW_W'(LATTICE_SIDE - 1);
   localparam logic signed [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(-2 * SITES);
   localparam logic signed [MAG_W-1:0]    MAG_RST    = MAG_W'(SITES);
   localparam logic signed [MAG_W-1:0]    MAG_TWO    = MAG_W'(2);

   // one-hot control: clearing pass, then normal run
   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } imf_state_type;

   imf_state_type state_ff, state_in;
   logic [ROW_W-1:0] clr_row_ff, clr_row_in;

   // configuration
   logic [DRAW_W-1:0] thr_four_ff;
   logic [DRAW_W-1:0] thr_eight_ff;
   logic              csr_wr;

   // request decode
   logic [SITE_W-1:0] req_row_raw;
   logic [SITE_W-1:0] req_col_raw;
   logic [DRAW_W-1:0] req_draw;
   logic [ROW_W-1:0]  req_row;
   logic [ROW_W-1:0]  req_col;
   logic [ROW_W-1:0]  req_row_up;
   logic [ROW_W-1:0]  req_row_dn;
   logic              req_fire;

   // out-of-range sites wrap: constant table of i mod side
   logic [ROW_W-1:0] site_mod [SITE_SPAN];

   // evaluate stage
   logic              s1_valid_ff, s1_valid_in;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [ROW_W-1:0]  s1_col_ff;
   logic [DRAW_W-1:0] s1_draw_ff;
   logic              s1_go;
   logic              s1_fire;

   // forwarding of a row written in the cycle the next request was read
   logic                    fwd_up_ff;
   logic                    fwd_dn_ff;
   logic                    fwd_ctr_ff;
   logic [LATTICE_SIDE-1:0] fwd_row_ff;

   // lattice ports
   logic                    wr_en;
   logic [ROW_W-1:0]        wr_addr;
   logic [LATTICE_SIDE-1:0] wr_data;
   logic [LATTICE_SIDE-1:0] up_row;
   logic [LATTICE_SIDE-1:0] dn_row;
   logic [LATTICE_SIDE-1:0] ctr_row;

   // trial datapath
   logic [LATTICE_SIDE-1:0] up_v;
   logic [LATTICE_SIDE-1:0] dn_v;
   logic [LATTICE_SIDE-1:0] ctr_v;
   logic [LATTICE_SIDE-1:0] new_row;
   logic [ROW_W-1:0]        col_lf;
   logic [ROW_W-1:0]        col_rt;
   logic                    spin_c;
   logic [2:0]              diff_cnt;
   logic signed [DE_W-1:0]  trial_de;
   logic                    trial_flip;

   // running totals
   logic signed [ENERGY_W-1:0] energy_ff, energy_in;
   logic signed [MAG_W-1:0]    mag_ff, mag_in;
   logic [CNT_W-1:0]           acc_ff, acc_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff;

   //------------------------------------------------------------------
   // Register port: always ready, index from the word-address bit
   //------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_four_ff  <= '0;
         thr_eight_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[CSR_AW-1])
            REG_THR_FOUR:  thr_four_ff  <= csr_pwdata;
            REG_THR_EIGHT: thr_eight_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_AW-1])
         REG_THR_FOUR:  csr_prdata = thr_four_ff;
         REG_THR_EIGHT: csr_prdata = thr_eight_ff;
         default:       csr_prdata = '0;
      endcase
   end

   //------------------------------------------------------------------
   // Clearing pass after reset: one row of +1 spins per cycle
   //------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      clr_row_in = clr_row_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + ROW_W'(1);
            if (clr_row_ff == LAST_ROW) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: ;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_row_ff <= clr_row_in;
      end
   end

   //------------------------------------------------------------------
   // Request decode and lattice read issue
   //------------------------------------------------------------------
   for (genvar gi = 0; gi < SITE_SPAN; gi++) begin : g_site_mod
      assign site_mod[gi] = ROW_W'(gi % LATTICE_SIDE);
   end

   assign req_row_raw = req_tdata[SITE_W-1:0];
   assign req_col_raw = req_tdata[2*SITE_W-1:SITE_W];
   assign req_draw    = req_tdata[2*SITE_W+DRAW_W-1:2*SITE_W];
   assign req_row     = site_mod[req_row_raw];
   assign req_col     = site_mod[req_col_raw];
   assign req_row_up  = (req_row == '0) ? LAST_ROW : req_row - ROW_W'(1);
   assign req_row_dn  = (req_row == LAST_ROW) ? '0 : req_row + ROW_W'(1);

   // evaluate stage moves on when the response slot is free or being taken
   assign s1_go      = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && s1_go;
   assign req_tready = (state_ff == ST_RUN) && (!s1_valid_ff || s1_go);
   assign req_fire   = req_tvalid && req_tready;

   // one write port: clearing rows, else the flipped center row
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_row_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_fire && trial_flip;
         wr_addr = s1_row_ff;
         wr_data = new_row;
      end
   end

   imf_lattice #(
      .LATTICE_SIDE (LATTICE_SIDE)
   ) u_lattice (
      .clock       (clock),
      .rd_en       (req_fire),
      .rd_up_addr  (req_row_up),
      .rd_dn_addr  (req_row_dn),
      .rd_ctr_addr (req_row),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .up_row      (up_row),
      .dn_row      (dn_row),
      .ctr_row     (ctr_row)
   );

   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // the memory read misses a write landing on the same edge: note it here
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_row_ff  <= req_row;
         s1_col_ff  <= req_col;
         s1_draw_ff <= req_draw;
         fwd_up_ff  <= wr_en && (wr_addr == req_row_up);
         fwd_dn_ff  <= wr_en && (wr_addr == req_row_dn);
         fwd_ctr_ff <= wr_en && (wr_addr == req_row);
         fwd_row_ff <= wr_data;
      end
   end

   //------------------------------------------------------------------
   // Trial: count neighbors that disagree with the center spin.
   // dE = 8 - 4 * disagree; two or more disagree means dE <= 0, taken.
   //------------------------------------------------------------------
   assign up_v  = fwd_up_ff  ? fwd_row_ff : up_row;
   assign dn_v  = fwd_dn_ff  ? fwd_row_ff : dn_row;
   assign ctr_v = fwd_ctr_ff ? fwd_row_ff : ctr_row;

   assign col_lf = (s1_col_ff == '0) ? LAST_ROW : s1_col_ff - ROW_W'(1);
   assign col_rt = (s1_col_ff == LAST_ROW) ? '0 : s1_col_ff + ROW_W'(1);

   assign spin_c   = ctr_v[s1_col_ff];
   assign diff_cnt = {2'b00, up_v[s1_col_ff] ^ spin_c}
                   + {2'b00, dn_v[s1_col_ff] ^ spin_c}
                   + {2'b00, ctr_v[col_lf] ^ spin_c}
                   + {2'b00, ctr_v[col_rt] ^ spin_c};

   always_comb begin
      case (diff_cnt)
         3'd0: begin
            trial_de   = 5'sd8;
            trial_flip = (s1_draw_ff <= thr_eight_ff);
         end
         3'd1: begin
            trial_de   = 5'sd4;
            trial_flip = (s1_draw_ff <= thr_four_ff);
         end
         3'd2: begin
            trial_de   = 5'sd0;
            trial_flip = 1'b1;
         end
         3'd3: begin
            trial_de   = -5'sd4;
            trial_flip = 1'b1;
         end
         3'd4: begin
            trial_de   = -5'sd8;
            trial_flip = 1'b1;
         end
         default: begin
            trial_de   = 5'sd0;
            trial_flip = 1'b0;
         end
      endcase
   end

   assign new_row = ctr_v ^ (LATTICE_SIDE'(1) << s1_col_ff);

   //------------------------------------------------------------------
   // Totals: exact inside, low bits out; flip of a +1 spin lowers
   // magnetization by two, of a -1 spin raises it by two
   //------------------------------------------------------------------
   always_comb begin
      energy_in = energy_ff;
      mag_in    = mag_ff;
      acc_in    = acc_ff;
      if (s1_fire && trial_flip) begin
         energy_in = energy_ff + ENERGY_W'(trial_de);
         mag_in    = spin_c ? mag_ff + MAG_TWO : mag_ff - MAG_TWO;
         if (acc_ff != '1) begin
            acc_in = acc_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= ENERGY_RST;
         mag_ff    <= MAG_RST;
         acc_ff    <= '0;
      end else begin
         energy_ff <= energy_in;
         mag_ff    <= mag_in;
         acc_ff    <= acc_in;
      end
   end

   //------------------------------------------------------------------
   // Response register
   //------------------------------------------------------------------
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= RSP_W'({acc_in, M_OUT_W'(mag_in), E_OUT_W'(energy_in),
                                trial_de, trial_flip});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   //------------------------------------------------------------------
   // Checks
   //------------------------------------------------------------------
   `IMF_ASSERT_ALWAYS(a_no_req_in_clear, clock, (state_ff == ST_CLEAR) |-> !req_tready)
   `IMF_ASSERT(a_energy_hold, clock, reset, !(s1_fire && trial_flip) |=> $stable(energy_ff))
   `IMF_ASSERT(a_count_step, clock, reset, (s1_fire && trial_flip && acc_ff != '1) |=> (acc_ff == $past(acc_ff) + CNT_W'(1)))
   `IMF_ASSERT(a_s1_hold, clock, reset, (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_row_ff)))
   `IMF_ASSERT(a_wr_only_on_flip, clock, reset, (state_ff == ST_RUN && wr_en) |-> (s1_fire && trial_flip))

endmodule

// ===== tb/ising_flip_checker.sv =====
// Checker for the Metropolis flip block: lattice predictor and response scoreboard
`timescale 1ns / 100ps

module ising_flip_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [imf_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [imf_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [imf_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [imf_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic                       csr_pready,
   output int                         fail_count,
   output int                         pending_count
);

   localparam int SIDE = imf_pkg::SIDE_DEFAULT;

   typedef struct {
      bit               flipped;
      bit signed [4:0]  energy_change;
      bit signed [14:0] total_energy;
      bit signed [13:0] total_magnetization;
      bit [31:0]        accepted_count;
   } trial_outcome_type;

   // 1 marks a down spin
   bit                spin_down [SIDE*SIDE];
   int                lattice_energy;
   int                lattice_magnet;
   bit [31:0]         flips_taken;
   bit [31:0]         thr_four;
   bit [31:0]         thr_eight;
   trial_outcome_type pending_outcomes [$];

   function automatic int spin_of(int r, int c);
      return spin_down[r*SIDE + c] ? -1 : 1;
   endfunction

   // one Metropolis trial on the shadow lattice
   function automatic trial_outcome_type run_trial(bit [5:0] row, bit [5:0] col,
                                                   bit [31:0] draw);
      trial_outcome_type res;
      int r, c, center, nsum, de;
      bit take;
      r = int'(row) % SIDE;
      c = int'(col) % SIDE;
      center = spin_of(r, c);
      nsum = spin_of((r + SIDE - 1) % SIDE, c) + spin_of((r + 1) % SIDE, c)
           + spin_of(r, (c + SIDE - 1) % SIDE) + spin_of(r, (c + 1) % SIDE);
      de = 2 * center * nsum;
      if (de <= 0) begin
         take = 1'b1;
      end else if (de == 4) begin
         take = draw <= thr_four;
      end else begin
         take = draw <= thr_eight;
      end
      if (take) begin
         spin_down[r*SIDE + c] = ~spin_down[r*SIDE + c];
         lattice_magnet -= 2 * center;
         lattice_energy += de;
         if (flips_taken != 32'hFFFF_FFFF) flips_taken++;
      end
      res.flipped = take;
      res.energy_change = de[4:0];
      res.total_energy = lattice_energy[14:0];
      res.total_magnetization = lattice_magnet[13:0];
      res.accepted_count = flips_taken;
      return res;
   endfunction

   function automatic void check_field(string what, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      trial_outcome_type want;
      if (reset) begin
         spin_down = '{default: 1'b0};
         lattice_energy = -2 * SIDE * SIDE;
         lattice_magnet = SIDE * SIDE;
         flips_taken = '0;
         thr_four = '0;
         thr_eight = '0;
         pending_outcomes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == imf_pkg::REG_THR_FOUR) begin
               thr_four = csr_pwdata;
            end else begin
               thr_eight = csr_pwdata;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: response with no trial pending, expected none, got %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("flipped", want.flipped, rsp_tdata[0]);
               check_field("energy_change", want.energy_change, $signed(rsp_tdata[5:1]));
               check_field("total_energy", want.total_energy, $signed(rsp_tdata[20:6]));
               check_field("total_magnetization", want.total_magnetization,
                           $signed(rsp_tdata[34:21]));
               check_field("accepted_count", want.accepted_count, rsp_tdata[66:35]);
            end
         end
         if (req_tvalid && req_tready) begin
            pending_outcomes.push_back(run_trial(req_tdata[5:0], req_tdata[11:6],
                                                 req_tdata[43:12]));
         end
      end
      pending_count <= pending_outcomes.size();
   end

endmodule

// ===== tb/tb_ising_metropolis_flip.sv =====
// Testbench top for the Metropolis flip block: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_ising_metropolis_flip;
   import imf_pkg::*;

   // register byte addresses, word index in paddr[2]
   localparam logic [CSR_AW-1:0] ADDR_THR_FOUR  = {REG_THR_FOUR, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_THR_EIGHT = {REG_THR_EIGHT, 2'b00};

   localparam int HOLD_CYCLES  = 300;       // long receiver hold-off, fills the pipe
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_ITEMS  = 190;
   localparam int LIMIT_CYCLES = 1000000;   // far above the slowest legal run

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   // [5:0] site_row, [11:6] site_col, [43:12] accept_draw, [47:44] zero
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // [0] flipped, [5:1] energy_change, [20:6] total_energy,
   // [34:21] total_magnetization, [66:35] accepted_count, [71:67] zero
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int fail_count;
   int pending_count;

   // hold-off handshake between the stimulus and the receiver process
   int holds_asked = 0;
   int holds_done  = 0;

   // stimulus state: current thresholds, site window, last site, burst length
   logic [31:0] thr_four_set  = '0;
   logic [31:0] thr_eight_set = '0;
   logic [5:0]  window_row, window_col;
   logic [5:0]  last_row = '0;
   logic [5:0]  last_col = '0;
   int          burst_left = 0;

   ising_metropolis_flip u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ising_flip_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_CYCLES * 20);
      $display("tb_ising_metropolis_flip: FAIL");
      $finish;
   end

   // sender idle length: mostly none or short, a few long, plus gap-free bursts;
   // no gaps at all while the receiver is held off so the block backs up
   function automatic int sender_gap();
      int roll;
      if (holds_asked != holds_done) return 0;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         burst_left = $urandom_range(10, 60);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver: random ready pattern, free-flow stretches, and the long hold-off
   initial begin : rsp_side
      int wait_left;
      int free_left;
      int roll;
      wait_left = 0;
      free_left = 0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else if (free_left > 0) begin
            free_left--;
            rsp_tready <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               free_left = $urandom_range(20, 80);
            end else if (roll < 30) begin
               wait_left = $urandom_range(1, 3);
            end else if (roll < 35) begin
               wait_left = $urandom_range(10, 40);
            end
         end
      end
   end

   // one request; valid stays high across back-to-back requests
   task automatic send_req(input logic [5:0] row, input logic [5:0] col,
                           input logic [31:0] draw);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {4'b0, draw, col, row};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      last_row = row;
      last_col = col;
   endtask

   // stop offering and wait until every response is back, plus pipeline slack
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_thresholds(input logic [31:0] four, input logic [31:0] eight);
      settle();
      write_csr(ADDR_THR_FOUR, four);
      write_csr(ADDR_THR_EIGHT, eight);
      thr_four_set = four;
      thr_eight_set = eight;
   endtask

   // draws cluster on the threshold edges now and then
   function automatic logic [31:0] pick_draw();
      case ($urandom_range(0, 9))
         0: return thr_four_set;
         1: return thr_four_set + 32'd1;
         2: return thr_eight_set;
         3: return thr_eight_set + 32'd1;
         4: return 32'h0000_0000;
         5: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // sites: mostly a small window so spins interact, some hitting the last
   // site or its neighbors back to back, the rest anywhere
   function automatic void pick_site(output logic [5:0] row, output logic [5:0] col);
      int roll;
      int off;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         off = $urandom_range(0, 3);
         row = window_row + off[5:0];
         off = $urandom_range(0, 3);
         col = window_col + off[5:0];
      end else if (roll < 75) begin
         off = $urandom_range(0, 2) - 1;
         row = last_row + off[5:0];
         off = $urandom_range(0, 2) - 1;
         col = last_col + off[5:0];
      end else begin
         row = 6'($urandom);
         col = 6'($urandom);
      end
   endfunction

   initial begin : stimulus
      logic [5:0] row, col;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // thresholds still at reset: a rise is taken only for a zero draw
      send_req(6'd0, 6'd0, 32'hFFFF_FFFF);   // rise of 8, rejected
      send_req(6'd0, 6'd0, 32'h0000_0000);   // draw equal to threshold: taken
      send_req(6'd63, 6'd63, 32'h0000_0000); // far corner
      send_req(6'd63, 6'd0, 32'hFFFF_FFFF);  // neighbors across both wrap edges
      send_req(6'd0, 6'd63, 32'h0000_0000);
      send_req(6'd20, 6'd20, 32'h0000_0000); // same site twice in a row:
      send_req(6'd20, 6'd20, 32'hFFFF_FFFF); //   flip back, fall of 8
      send_req(6'd10, 6'd10, 32'h0000_0000);
      send_req(6'd10, 6'd11, 32'h0000_0001); // rise of 4, draw just above zero

      // mid-scale thresholds, draws on either side of the edge
      set_thresholds(32'h8000_0000, 32'h7FFF_FFFF);
      send_req(6'd10, 6'd11, 32'h8000_0001); // rise of 4, one above: rejected
      send_req(6'd10, 6'd11, 32'h8000_0000); // rise of 4, equal: taken
      send_req(6'd10, 6'd11, 32'hFFFF_FFFF); // fall of 4
      send_req(6'd30, 6'd30, 32'h7FFF_FFFF); // rise of 8, equal: taken
      send_req(6'd30, 6'd40, 32'h8000_0000); // rise of 8, one above: rejected
      send_req(6'd31, 6'd30, 32'h0000_0000);

      // full-scale thresholds: every rise taken even for the largest draw
      set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(6'd40, 6'd5, 32'hFFFF_FFFF);
      send_req(6'd41, 6'd5, 32'hFFFF_FFFF);
      send_req(6'd40, 6'd6, 32'hFFFF_FFFF);
      send_req(6'd41, 6'd6, 32'hFFFF_FFFF);

      // random phases, each with its own threshold pair and site window
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         case (phase)
            0, 7:    set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2:       set_thresholds(32'h0000_0000, 32'h0000_0000);
            3:       set_thresholds(32'hFFFF_FFFF, 32'h0000_0000);
            4:       set_thresholds(32'h0000_0000, 32'hFFFF_FFFF);
            default: set_thresholds($urandom, $urandom);
         endcase
         if (phase % 2 == 0) begin
            window_row = 6'd62;   // window straddles the wrap in both axes
            window_col = 6'd62;
         end else begin
            window_row = 6'($urandom);
            window_col = 6'($urandom);
         end
         // receiver holds off while the sender keeps pushing
         if (phase == 2) holds_asked++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick_site(row, col);
            send_req(row, col, pick_draw());
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_ising_metropolis_flip: PASS");
      end else begin
         $display("tb_ising_metropolis_flip: FAIL");
      end
      $finish;
   end

endmodule
